@@ design/spi_flash_command_sequencer_defines.svh @@
// assertion macros shared by the serial-flash command sequencer modules
`ifndef SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SPFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spfc assertion failed");

// antecedent implies consequent in the next cycle
`define SPFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spfc assertion failed");

`endif

@@ design/spfc_pkg.sv @@
// types, opcodes and the per-step byte table of the serial-flash command sequencer
package spfc_pkg;

   // flash opcodes
   localparam logic [7:0] OP_FAST_READ = 8'h0B;
   localparam logic [7:0] OP_WREN      = 8'h06;
   localparam logic [7:0] OP_WRDI      = 8'h04;
   localparam logic [7:0] OP_ERASE4K   = 8'h20;
   localparam logic [7:0] OP_AAI       = 8'hAD;
   localparam logic [7:0] OP_PROGRAM   = 8'h02;
   localparam logic [7:0] OP_EOW_ON    = 8'h70;
   localparam logic [7:0] OP_EOW_OFF   = 8'h80;
   localparam logic [7:0] OP_EWSR      = 8'h50;
   localparam logic [7:0] OP_WRSR      = 8'h01;
   localparam logic [7:0] STATUS_CLEAR = 8'h00;
   localparam logic [7:0] DUMMY_BYTE   = 8'hFF;
   localparam logic [23:0] ADDR_FULL   = 24'hFFFFFF;

   // status register write-enable latch position
   localparam int WEL_POS = 1;

   // request commands
   localparam logic [1:0] CMD_ERASE   = 2'd0;
   localparam logic [1:0] CMD_PROGRAM = 2'd1;
   localparam logic [1:0] CMD_STREAM  = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   // wait markers after a frame
   localparam logic [1:0] WAIT_NONE = 2'd0;
   localparam logic [1:0] WAIT_BUSY = 2'd1;
   localparam logic [1:0] WAIT_DOUT = 2'd2;

   // steps of the longest byte sequence
   localparam int STEPS = 16;
   localparam int POS_BITS = $clog2(STEPS);

   typedef enum logic [1:0] {
      JOB_ERASE = 2'd0,
      JOB_WRITE = 2'd1,
      JOB_READ  = 2'd2
   } job_kind_type;

   // one queued job: which steps of its sequence to emit and their operands
   typedef struct packed {
      job_kind_type     kind;
      logic [STEPS-1:0] mask;
      logic [23:0]      addr;
      logic [7:0]       pend;
      logic [7:0]       data;
      logic             last;
   } job_type;

   // one emitted byte with its framing
   typedef struct packed {
      logic [7:0] spi_byte;
      logic       frame_start;
      logic       frame_end;
      logic [1:0] wait_mode;
   } step_type;

   function automatic step_type mk(logic [7:0] b, logic st, logic en, logic [1:0] w);
      step_type s;
      s.spi_byte    = b;
      s.frame_start = st;
      s.frame_end   = en;
      s.wait_mode   = w;
      return s;
   endfunction

   // byte emitted at a given step of a job's sequence
   function automatic step_type step_out(job_type job, logic [POS_BITS-1:0] pos);
      step_type s;
      s = mk(DUMMY_BYTE, 1'b0, 1'b0, WAIT_NONE);
      case (job.kind)
         JOB_ERASE: begin
            case (pos)
               4'd0:    s = mk(OP_EWSR, 1'b1, 1'b1, WAIT_NONE);
               4'd1:    s = mk(OP_WRSR, 1'b1, 1'b0, WAIT_NONE);
               4'd2:    s = mk(STATUS_CLEAR, 1'b0, 1'b1, WAIT_NONE);
               4'd3:    s = mk(OP_WREN, 1'b1, 1'b1, WAIT_NONE);
               4'd4:    s = mk(OP_ERASE4K, 1'b1, 1'b0, WAIT_NONE);
               4'd5:    s = mk(job.addr[23:16], 1'b0, 1'b0, WAIT_NONE);
               4'd6:    s = mk(job.addr[15:8], 1'b0, 1'b0, WAIT_NONE);
               4'd7:    s = mk(job.addr[7:0], 1'b0, 1'b1, WAIT_BUSY);
               default: s = mk(DUMMY_BYTE, 1'b0, 1'b0, WAIT_NONE);
            endcase
         end
         JOB_WRITE: begin
            case (pos)
               4'd0:    s = mk(OP_WREN, 1'b1, 1'b1, WAIT_NONE);
               4'd1:    s = mk(OP_EOW_ON, 1'b1, 1'b1, WAIT_NONE);
               4'd2:    s = mk(OP_AAI, 1'b1, 1'b0, WAIT_NONE);
               4'd3:    s = mk(job.addr[23:16], 1'b0, 1'b0, WAIT_NONE);
               4'd4:    s = mk(job.addr[15:8], 1'b0, 1'b0, WAIT_NONE);
               4'd5:    s = mk(job.addr[7:0], 1'b0, 1'b0, WAIT_NONE);
               4'd6:    s = mk(job.pend, 1'b0, 1'b0, WAIT_NONE);
               4'd7:    s = mk(job.data, 1'b0, 1'b1, WAIT_DOUT);
               4'd8:    s = mk(OP_WRDI, 1'b1, 1'b1, WAIT_NONE);
               4'd9:    s = mk(OP_EOW_OFF, 1'b1, 1'b1, WAIT_NONE);
               4'd10:   s = mk(OP_WREN, 1'b1, 1'b1, WAIT_NONE);
               4'd11:   s = mk(OP_PROGRAM, 1'b1, 1'b0, WAIT_NONE);
               4'd12:   s = mk(job.addr[23:16], 1'b0, 1'b0, WAIT_NONE);
               4'd13:   s = mk(job.addr[15:8], 1'b0, 1'b0, WAIT_NONE);
               4'd14:   s = mk(job.addr[7:0], 1'b0, 1'b0, WAIT_NONE);
               default: s = mk(job.data, 1'b0, 1'b1, WAIT_NONE);
            endcase
         end
         JOB_READ: begin
            case (pos)
               4'd0:    s = mk(OP_FAST_READ, 1'b1, 1'b0, WAIT_NONE);
               4'd1:    s = mk(job.addr[23:16], 1'b0, 1'b0, WAIT_NONE);
               4'd2:    s = mk(job.addr[15:8], 1'b0, 1'b0, WAIT_NONE);
               4'd3:    s = mk(job.addr[7:0], 1'b0, 1'b0, WAIT_NONE);
               4'd4:    s = mk(DUMMY_BYTE, 1'b0, 1'b0, WAIT_NONE);
               default: s = mk(DUMMY_BYTE, 1'b0, job.last, WAIT_NONE);
            endcase
         end
         default: s = mk(DUMMY_BYTE, 1'b0, 1'b0, WAIT_NONE);
      endcase
      return s;
   endfunction

endpackage

@@ design/spi_flash_command_sequencer.sv @@
// top level of the serial-flash command sequencer
//
// Requests (erase, byte program, stream write byte, read byte) enter on the
// req_ channel; the command bytes they cause leave on the rsp_ channel, one
// transfer per byte, with chip-select framing, a wait marker on some
// frame-ending bytes and rsp_last_of_run on the final byte of each request.
// The front end classifies a request in the cycle it is taken and pushes a
// job into a QUEUE_DEPTH-entry queue; req_ready is low only while that queue
// is full. Requests that cause no bytes (a non-final stream byte that opens
// a pair other than the first, ignored foreign commands) queue nothing.
// The byte sequencer emits one byte per cycle while rsp_ready does not stall
// it and loads the next job as a request's last byte leaves. A request has
// 0 to 10 bytes; its job goes through the queue and the current-job register
// to the output register. A stalled rsp_ready holds the output register; the
// sequencer and queue back up behind it and new requests are taken until the
// queue fills. Reset clears the burst state, queue and any byte in flight.
module spi_flash_command_sequencer #(
   parameter int ADDR_BITS   = 24,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [23:0] req_address,
   input  logic [7:0]  req_data,
   input  logic        req_last,
   input  logic [7:0]  req_status_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_spi_byte,
   output logic        rsp_frame_start,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_wait_mode,
   output logic        rsp_last_of_run
);

   logic              push_valid;
   logic              push_ready;
   spfc_pkg::job_type push_job;
   logic              pop_valid;
   logic              pop_ready;
   spfc_pkg::job_type pop_job;

   // request front end
   spfc_front #(
      .ADDR_BITS(ADDR_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_data        (req_data),
      .req_last        (req_last),
      .req_status_byte (req_status_byte),
      .q_valid         (push_valid),
      .q_ready         (push_ready),
      .q_job           (push_job)
   );

   // job queue
   spfc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // byte sequencer
   spfc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_job         (pop_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_spi_byte    (rsp_spi_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_wait_mode   (rsp_wait_mode),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ design/spfc_front.sv @@
// front end: accepts requests, tracks stream and read bursts, builds jobs
module spfc_front #(
   parameter int ADDR_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [23:0]       req_address,
   input  logic [7:0]        req_data,
   input  logic              req_last,
   input  logic [7:0]        req_status_byte,
   output logic              q_valid,
   input  logic              q_ready,
   output spfc_pkg::job_type q_job
);

   localparam logic [23:0] ADDR_MASK = (ADDR_BITS >= 24) ? spfc_pkg::ADDR_FULL :
                                       24'((64'd1 << ADDR_BITS) - 64'd1);

   logic        stream_active_ff, stream_active_in;
   logic        pending_valid_ff, pending_valid_in;
   logic [7:0]  pending_byte_ff, pending_byte_in;
   logic        first_pair_ff, first_pair_in;
   logic [23:0] stream_address_ff, stream_address_in;
   logic        read_active_ff, read_active_in;

   logic        accept;
   logic        ignore;
   logic        wel;
   logic [23:0] maddr;
   logic        start;
   logic        pend_v;
   logic        fp;
   logic        pair;
   logic [23:0] saddr;
   spfc_pkg::job_type job;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign wel       = req_status_byte[spfc_pkg::WEL_POS];
   assign maddr     = req_address & ADDR_MASK;
   assign ignore    = (stream_active_ff && (req_command != spfc_pkg::CMD_STREAM)) ||
                      (read_active_ff && (req_command != spfc_pkg::CMD_READ));

   // stream view of this item
   assign start  = !stream_active_ff;
   assign pend_v = start ? 1'b0 : pending_valid_ff;
   assign fp     = start ? 1'b1 : first_pair_ff;
   assign saddr  = start ? maddr : stream_address_ff;
   assign pair   = pend_v;

   // classify the request into a job and next burst state
   always_comb begin
      job.kind = spfc_pkg::JOB_ERASE;
      job.mask = '0;
      job.addr = maddr;
      job.pend = pending_byte_ff;
      job.data = req_data;
      job.last = req_last;
      stream_active_in  = stream_active_ff;
      pending_valid_in  = pending_valid_ff;
      pending_byte_in   = pending_byte_ff;
      first_pair_in     = first_pair_ff;
      stream_address_in = stream_address_ff;
      read_active_in    = read_active_ff;
      if (!ignore) begin
         case (req_command)
            spfc_pkg::CMD_ERASE: begin
               job.kind = spfc_pkg::JOB_ERASE;
               job.mask = 16'h00FF;
            end
            spfc_pkg::CMD_PROGRAM: begin
               job.kind     = spfc_pkg::JOB_WRITE;
               job.mask     = 16'hF800;
               job.mask[10] = !wel;
            end
            spfc_pkg::CMD_STREAM: begin
               job.kind     = spfc_pkg::JOB_WRITE;
               job.addr     = saddr;
               job.mask[0]  = start && !wel;
               job.mask[1]  = start;
               job.mask[2]  = pair;
               job.mask[3]  = pair && fp;
               job.mask[4]  = pair && fp;
               job.mask[5]  = pair && fp;
               job.mask[6]  = pair;
               job.mask[7]  = pair;
               job.mask[8]  = req_last;
               job.mask[9]  = req_last;
               job.mask[15:10] = {6{req_last && !pair}};
               if (pair) begin
                  pending_valid_in  = 1'b0;
                  first_pair_in     = 1'b0;
                  stream_address_in = saddr + 24'd2;
               end else begin
                  pending_valid_in  = 1'b1;
                  pending_byte_in   = req_data;
                  first_pair_in     = fp;
                  stream_address_in = saddr;
               end
               stream_active_in = 1'b1;
               if (req_last) begin
                  stream_active_in = 1'b0;
                  pending_valid_in = 1'b0;
                  first_pair_in    = 1'b1;
               end
            end
            default: begin
               job.kind       = spfc_pkg::JOB_READ;
               job.mask[4:0]  = {5{!read_active_ff}};
               job.mask[5]    = 1'b1;
               read_active_in = !req_last;
            end
         endcase
      end
   end

   assign q_job   = job;
   assign q_valid = req_valid && (job.mask != '0);

   // burst state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_active_ff  <= 1'b0;
         pending_valid_ff  <= 1'b0;
         pending_byte_ff   <= 8'd0;
         first_pair_ff     <= 1'b1;
         stream_address_ff <= 24'd0;
         read_active_ff    <= 1'b0;
      end else if (accept) begin
         stream_active_ff  <= stream_active_in;
         pending_valid_ff  <= pending_valid_in;
         pending_byte_ff   <= pending_byte_in;
         first_pair_ff     <= first_pair_in;
         stream_address_ff <= stream_address_in;
         read_active_ff    <= read_active_in;
      end
   end

endmodule

@@ design/spfc_queue.sv @@
// job queue between the front end and the byte sequencer
`include "spi_flash_command_sequencer_defines.svh"

module spfc_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  spfc_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output spfc_pkg::job_type pop_job
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   spfc_pkg::job_type mem_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `SPFC_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `SPFC_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop,
                     count_ff == $past(count_ff) + CW'(1))

endmodule

@@ design/spfc_back.sv @@
// back end: walks a job's steps and emits one command byte per cycle unless rsp_ready stalls the output
`include "spi_flash_command_sequencer_defines.svh"

module spfc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  spfc_pkg::job_type pop_job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_spi_byte,
   output logic              rsp_frame_start,
   output logic              rsp_frame_end,
   output logic [1:0]        rsp_wait_mode,
   output logic              rsp_last_of_run
);

   localparam int STEPS = spfc_pkg::STEPS;
   localparam int PW    = spfc_pkg::POS_BITS;

   logic              cur_valid_ff, cur_valid_in;
   spfc_pkg::job_type cur_job_ff, cur_job_in;
   logic [STEPS-1:0]  rem_ff, rem_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_spi_byte_ff, rsp_spi_byte_in;
   logic              rsp_frame_start_ff, rsp_frame_start_in;
   logic              rsp_frame_end_ff, rsp_frame_end_in;
   logic [1:0]        rsp_wait_mode_ff, rsp_wait_mode_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [STEPS-1:0]  low;
   logic [STEPS-1:0]  rem_after;
   logic [PW-1:0]     pos;
   spfc_pkg::step_type step;
   logic              fire;
   logic              done;
   logic              load;

   // pick the lowest remaining step
   always_comb begin
      low = rem_ff & (~rem_ff + STEPS'(1));
      pos = '0;
      for (int i = 0; i < STEPS; i++) begin
         if (low[i]) begin
            pos = pos | PW'(i);
         end
      end
      rem_after = rem_ff & ~low;
      step      = spfc_pkg::step_out(cur_job_ff, pos);
   end

   assign fire      = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign done      = fire && (rem_after == '0);
   assign load      = !cur_valid_ff || done;
   assign pop_ready = load;

   // current job and output register next values
   always_comb begin
      cur_valid_in       = cur_valid_ff;
      cur_job_in         = cur_job_ff;
      rem_in             = rem_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_spi_byte_in    = rsp_spi_byte_ff;
      rsp_frame_start_in = rsp_frame_start_ff;
      rsp_frame_end_in   = rsp_frame_end_ff;
      rsp_wait_mode_in   = rsp_wait_mode_ff;
      rsp_last_in        = rsp_last_ff;
      if (load) begin
         cur_valid_in = pop_valid;
         cur_job_in   = pop_job;
         rem_in       = pop_job.mask;
      end else if (fire) begin
         rem_in = rem_after;
      end
      if (fire) begin
         rsp_valid_in       = 1'b1;
         rsp_spi_byte_in    = step.spi_byte;
         rsp_frame_start_in = step.frame_start;
         rsp_frame_end_in   = step.frame_end;
         rsp_wait_mode_in   = step.wait_mode;
         rsp_last_in        = rem_after == '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_job_ff         <= cur_job_in;
      rem_ff             <= rem_in;
      rsp_spi_byte_ff    <= rsp_spi_byte_in;
      rsp_frame_start_ff <= rsp_frame_start_in;
      rsp_frame_end_ff   <= rsp_frame_end_in;
      rsp_wait_mode_ff   <= rsp_wait_mode_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_spi_byte    = rsp_spi_byte_ff;
   assign rsp_frame_start = rsp_frame_start_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;
   assign rsp_wait_mode   = rsp_wait_mode_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `SPFC_ASSERT_IMPL(a_cur_has_steps, clock, reset, cur_valid_ff, rem_ff != '0)
   `SPFC_ASSERT_IMPL(a_wait_ends_frame, clock, reset,
                     rsp_valid_ff && (rsp_wait_mode_ff != spfc_pkg::WAIT_NONE),
                     rsp_frame_end_ff)
   `SPFC_ASSERT_NEXT(a_done_marks_last, clock, reset, done, rsp_valid_ff && rsp_last_ff)

endmodule
